>>> hdl/wnwt_pkg.sv
// shared types and constants for the windowed nearest waypoint tracker
// no dependencies; used by the interfaces and every module of the block

package wnwt_pkg;

  localparam int COORD_W        = 24;
  localparam int IDX_W          = 10;
  localparam int OFS_W          = 5;
  localparam int SQ_W           = 49;
  localparam int PATH_DEPTH_DEF = 1024;
  localparam int WINDOW_DEF     = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    logic clear;
    logic append;
    logic scan_start;
    logic scan_issue;
    logic adopt;
    logic emit_read;
    logic load_point;
    logic load_empty;
  } ctl_cmd_t;

  typedef struct packed {
    logic win_empty;
    logic ptr_last;
    logic pipe_busy;
    logic out_free;
    logic rd_last;
  } dp_status_t;

endpackage

>>> hdl/wnwt_if.sv
// valid/ready channels of the tracker: input words and result words
// depends on wnwt_pkg for field widths

interface wnwt_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic signed [wnwt_pkg::COORD_W-1:0] coord_x;
  logic signed [wnwt_pkg::COORD_W-1:0] coord_y;

  modport source (output valid, opcode, coord_x, coord_y, input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, output ready);
endinterface

interface wnwt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              valid_res;
  logic [wnwt_pkg::IDX_W-1:0]        point_index;
  logic signed [wnwt_pkg::COORD_W-1:0] point_x;
  logic signed [wnwt_pkg::COORD_W-1:0] point_y;
  logic [wnwt_pkg::OFS_W-1:0]        nearest_offset;
  logic                              last;

  modport source (output valid, valid_res, point_index, point_x, point_y, nearest_offset, last,
                  input ready);
  modport sink   (input valid, valid_res, point_index, point_x, point_y, nearest_offset, last,
                  output ready);
endinterface

>>> hdl/wnwt_ctrl.sv
// sequencer of the tracker: decodes input words and steps scan, drain and emit
// depends on wnwt_pkg; drives command bits to wnwt_datapath

module wnwt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_opcode_i,
  output logic                 in_ready_o,
  input  wnwt_pkg::dp_status_t status_i,
  output wnwt_pkg::ctl_cmd_t   cmd_o
);

  wnwt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wnwt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      wnwt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (wnwt_pkg::op_e'(in_opcode_i))
            wnwt_pkg::OP_CLEAR:  cmd_o.clear = 1'b1;
            wnwt_pkg::OP_APPEND: cmd_o.append = 1'b1;
            wnwt_pkg::OP_QUERY: begin
              if (status_i.win_empty) begin
                state_d = wnwt_pkg::ST_EMPTY;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = wnwt_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      wnwt_pkg::ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.ptr_last) begin
          state_d = wnwt_pkg::ST_DRAIN;
        end
      end
      wnwt_pkg::ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          cmd_o.adopt = 1'b1;
          state_d     = wnwt_pkg::ST_EMIT_RD;
        end
      end
      wnwt_pkg::ST_EMIT_RD: begin
        cmd_o.emit_read = 1'b1;
        state_d         = wnwt_pkg::ST_EMIT_LD;
      end
      wnwt_pkg::ST_EMIT_LD: begin
        // the next point is fetched in the same cycle its predecessor loads
        if (status_i.out_free) begin
          cmd_o.load_point = 1'b1;
          if (status_i.rd_last) begin
            state_d = wnwt_pkg::ST_IDLE;
          end else begin
            cmd_o.emit_read = 1'b1;
          end
        end
      end
      wnwt_pkg::ST_EMPTY: begin
        if (status_i.out_free) begin
          cmd_o.load_empty = 1'b1;
          state_d          = wnwt_pkg::ST_IDLE;
        end
      end
      default: state_d = wnwt_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> hdl/wnwt_datapath.sv
// path memory, tracking index, distance pipeline and result register
// depends on wnwt_pkg; commanded by wnwt_ctrl

module wnwt_datapath #(
  parameter int PATH_DEPTH = wnwt_pkg::PATH_DEPTH_DEF,
  parameter int WINDOW     = wnwt_pkg::WINDOW_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wnwt_pkg::ctl_cmd_t                  cmd_i,
  output wnwt_pkg::dp_status_t                status_o,
  input  logic signed [wnwt_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [wnwt_pkg::COORD_W-1:0] coord_y_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                valid_res_o,
  output logic [wnwt_pkg::IDX_W-1:0]          point_index_o,
  output logic signed [wnwt_pkg::COORD_W-1:0] point_x_o,
  output logic signed [wnwt_pkg::COORD_W-1:0] point_y_o,
  output logic [wnwt_pkg::OFS_W-1:0]          nearest_offset_o,
  output logic                                last_o
);

  localparam int AW  = $clog2(PATH_DEPTH);
  localparam int CW  = $clog2(PATH_DEPTH + 1);
  localparam int OW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WW  = $clog2(WINDOW + 1);
  localparam int CDW = wnwt_pkg::COORD_W;
  localparam int DW  = CDW + 1;
  localparam int SQW = wnwt_pkg::SQ_W;

  logic [2*CDW-1:0] path_mem_q [PATH_DEPTH];

  logic [CW-1:0]  count_q;
  logic [AW-1:0]  start_q;
  logic [OW-1:0]  ptr_q;
  logic [WW-1:0]  win_len;
  logic [CW-1:0]  avail;

  logic signed [CDW-1:0] vx_q, vy_q;

  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic [2*CDW-1:0] rd_q;
  logic [AW-1:0]  rd_idx_q;
  logic           rd_last_q;

  logic           v1_q, v2_q, v3_q;
  logic [OW-1:0]  off1_q, off2_q, off3_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [2*DW-1:0] prod_x, prod_y;
  logic [SQW-1:0] sqx_q, sqy_q;
  logic [SQW:0]   dist_sum;
  logic [SQW:0]   best_d_q;
  logic [OW-1:0]  best_q;

  logic           out_valid_q, valid_res_q, last_q;
  logic [wnwt_pkg::IDX_W-1:0] index_q;
  logic [CDW-1:0] px_q, py_q;
  logic [wnwt_pkg::OFS_W-1:0] ofs_q;
  logic           out_free;
  logic [31:0]    idx_wide, ofs_wide;

  // window length from the current start index
  always_comb begin
    avail   = CW'(32'(count_q) - 32'(start_q));
    win_len = '0;
    if (32'(start_q) < 32'(count_q)) begin
      if (32'(avail) < 32'(WINDOW)) begin
        win_len = WW'(avail);
      end else begin
        win_len = WW'(WINDOW);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.win_empty = (win_len == '0);
  assign status_o.ptr_last  = (32'(ptr_q) + 32'd1 == 32'(win_len));
  assign status_o.pipe_busy = v1_q || v2_q || v3_q;
  assign status_o.out_free  = out_free;
  assign status_o.rd_last   = rd_last_q;

  assign rd_en   = cmd_i.scan_issue || cmd_i.emit_read;
  assign rd_addr = AW'(32'(start_q) + 32'(ptr_q));

  // path memory, written by appends, read one word a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.append && (32'(count_q) < PATH_DEPTH)) begin
      path_mem_q[count_q[AW-1:0]] <= {coord_x_i, coord_y_i};
    end
    if (rd_en) begin
      rd_q      <= path_mem_q[rd_addr];
      rd_idx_q  <= rd_addr;
      rd_last_q <= status_o.ptr_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      start_q <= '0;
      ptr_q   <= '0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
        start_q <= '0;
      end else if (cmd_i.append && (32'(count_q) < PATH_DEPTH)) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.adopt) begin
        start_q <= AW'(32'(start_q) + 32'(best_q));
      end
      if (cmd_i.scan_start || cmd_i.adopt) begin
        ptr_q <= '0;
      end else if (rd_en) begin
        ptr_q <= ptr_q + OW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      vx_q <= coord_x_i;
      vy_q <= coord_y_i;
    end
  end

  // distance pipeline: read, difference, square, compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.scan_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign prod_x   = dx_q * dx_q;
  assign prod_y   = dy_q * dy_q;
  assign dist_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_issue) begin
      off1_q <= ptr_q;
    end
    if (v1_q) begin
      dx_q   <= $signed({vx_q[CDW-1], vx_q}) - $signed({rd_q[2*CDW-1], rd_q[2*CDW-1:CDW]});
      dy_q   <= $signed({vy_q[CDW-1], vy_q}) - $signed({rd_q[CDW-1], rd_q[CDW-1:0]});
      off2_q <= off1_q;
    end
    if (v2_q) begin
      sqx_q  <= prod_x[SQW-1:0];
      sqy_q  <= prod_y[SQW-1:0];
      off3_q <= off2_q;
    end
    // strict compare keeps the lowest offset on ties
    if (v3_q && ((off3_q == '0) || (dist_sum < best_d_q))) begin
      best_d_q <= dist_sum;
      best_q   <= off3_q;
    end
  end

  // result register
  assign idx_wide = 32'(rd_idx_q);
  assign ofs_wide = 32'(best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_point || cmd_i.load_empty) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_point) begin
      valid_res_q <= 1'b1;
      index_q     <= idx_wide[wnwt_pkg::IDX_W-1:0];
      px_q        <= rd_q[2*CDW-1:CDW];
      py_q        <= rd_q[CDW-1:0];
      ofs_q       <= ofs_wide[wnwt_pkg::OFS_W-1:0];
      last_q      <= rd_last_q;
    end else if (cmd_i.load_empty) begin
      valid_res_q <= 1'b0;
      index_q     <= '0;
      px_q        <= '0;
      py_q        <= '0;
      ofs_q       <= '0;
      last_q      <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign valid_res_o      = valid_res_q;
  assign point_index_o    = index_q;
  assign point_x_o        = $signed(px_q);
  assign point_y_o        = $signed(py_q);
  assign nearest_offset_o = ofs_q;
  assign last_o           = last_q;

  a_start_in_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) ? (start_q == '0) : (32'(start_q) < 32'(count_q)))
    else $error("start index outside stored path");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= PATH_DEPTH)
    else $error("point count beyond path depth");

  a_adopt_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.adopt |-> !(v1_q || v2_q || v3_q))
    else $error("start index moved while distances in flight");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_point || cmd_i.load_empty) |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before taken");

  a_scan_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (32'(ptr_q) < 32'(win_len)))
    else $error("read beyond current window");

endmodule

>>> hdl/windowed_nearest_waypoint_tracker.sv
// Windowed nearest waypoint tracker: clear and append words are taken in the idle state.
// A query over a window of n points issues n reads, drains the distance pipeline
// (read, difference, square, compare), moves the start index, then emits one word
// a cycle of the new window while the output is free; an empty window gives one word.
// One word at a time; the single-port path memory read sets the scan and emit pace.
// Reset clears point count, start index and control; the path memory is not cleared.

module windowed_nearest_waypoint_tracker #(
  parameter int PATH_DEPTH = wnwt_pkg::PATH_DEPTH_DEF,
  parameter int WINDOW     = wnwt_pkg::WINDOW_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wnwt_in_if.sink    in_i,
  wnwt_out_if.source res_o
);

  wnwt_pkg::ctl_cmd_t   cmd;
  wnwt_pkg::dp_status_t status;
  logic                 in_ready;

  wnwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .in_ready_o  (in_ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wnwt_datapath #(
    .PATH_DEPTH (PATH_DEPTH),
    .WINDOW     (WINDOW)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .coord_x_i        (in_i.coord_x),
    .coord_y_i        (in_i.coord_y),
    .out_ready_i      (res_o.ready),
    .out_valid_o      (res_o.valid),
    .valid_res_o      (res_o.valid_res),
    .point_index_o    (res_o.point_index),
    .point_x_o        (res_o.point_x),
    .point_y_o        (res_o.point_y),
    .nearest_offset_o (res_o.nearest_offset),
    .last_o           (res_o.last)
  );

  assign in_i.ready = in_ready;

endmodule
